[rtl/swc_pkg.sv]
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types and constants of the segment wall crossing unit.
// ----------------------------------------------------------------------------
package swc_pkg;

  // default number of fraction bits of a coordinate
  localparam int unsigned FRAC_BITS_DEF = 16;
  // fraction bits of the crossing parameter t and of unit vectors
  localparam int unsigned T_FRAC        = 30;
  localparam int unsigned VEC_FRAC      = 14;
  // quotient width: t may reach exactly 1.0
  localparam int unsigned T_W           = T_FRAC + 1;
  // radius register
  localparam int unsigned RAD_W         = 23;
  localparam logic [RAD_W-1:0] RADIUS_RST = 23'd327680;

  // command codes
  localparam logic CMD_COLLIDE = 1'b0;
  localparam logic CMD_OCCLUDE = 1'b1;

  // one accepted input transaction
  typedef struct packed {
    logic               occl;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [47:0]        len;
  } swc_in_t;

  // context carried alongside the divider
  typedef struct packed {
    logic               occl;
    logic               go;    // side test passed, extent test pending
    logic               nz;    // divisor nonzero, crossing point interpolated
    logic               neg;   // t negative
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [32:0] dex;
    logic signed [32:0] dey;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [47:0]        len;
  } swc_ctx_t;

endpackage

[rtl/swc_front.sv]
// ----------------------------------------------------------------------------
// swc_front
// Side test against the wall line and divisor normalisation, four stages.
// ----------------------------------------------------------------------------
module swc_front import swc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  swc_in_t     item_i,
  output logic        valid_o,
  output swc_ctx_t    ctx_o,
  output logic [31:0] num_o,
  output logic [31:0] den_o
);

  // stage 1: offsets from the wall point
  logic               v1_q;
  swc_in_t            it1_q;
  logic signed [32:0] qsx_q, qsy_q, qex_q, qey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it1_q <= item_i;
      qsx_q <= {item_i.sx[31], item_i.sx} - {item_i.wx[31], item_i.wx};
      qsy_q <= {item_i.sy[31], item_i.sy} - {item_i.wy[31], item_i.wy};
      qex_q <= {item_i.ex[31], item_i.ex} - {item_i.wx[31], item_i.wx};
      qey_q <= {item_i.ey[31], item_i.ey} - {item_i.wy[31], item_i.wy};
    end
  end

  // stage 2: projections on the normal, path deltas
  logic               v2_q;
  swc_in_t            it2_q;
  logic signed [32:0] dex2_q, dey2_q;
  logic signed [48:0] psx_q, psy_q, pex_q, pey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it2_q  <= it1_q;
      dex2_q <= {it1_q.ex[31], it1_q.ex} - {it1_q.sx[31], it1_q.sx};
      dey2_q <= {it1_q.ey[31], it1_q.ey} - {it1_q.sy[31], it1_q.sy};
      psx_q  <= qsx_q * it1_q.nx;
      psy_q  <= qsy_q * it1_q.ny;
      pex_q  <= qex_q * it1_q.nx;
      pey_q  <= qey_q * it1_q.ny;
    end
  end

  // stage 3: signed distances, side decision, magnitudes
  logic signed [49:0] ds, de;
  logic signed [50:0] s2;
  logic               ds_pos, ds_neg, de_pos, de_neg, same;
  logic [49:0]        amag;
  logic [50:0]        bmag;
  swc_ctx_t           ctx3_d;

  always_comb begin
    ds     = {psx_q[48], psx_q} + {psy_q[48], psy_q};
    de     = {pex_q[48], pex_q} + {pey_q[48], pey_q};
    s2     = {de[49], de} - {ds[49], ds};
    ds_neg = ds[49];
    ds_pos = !ds[49] && (ds != '0);
    de_neg = de[49];
    de_pos = !de[49] && (de != '0);
    same   = (ds_pos && de_pos) || (ds_neg && de_neg);
    amag   = ds_neg ? 50'(-ds) : 50'(ds);
    bmag   = s2[50] ? 51'(-s2) : 51'(s2);
    ctx3_d.occl = it2_q.occl;
    ctx3_d.go   = !same && ((it2_q.occl == CMD_OCCLUDE) || !ds_pos);
    ctx3_d.nz   = (s2 != '0);
    ctx3_d.neg  = ds_pos != s2[50];
    ctx3_d.sx   = it2_q.sx;
    ctx3_d.sy   = it2_q.sy;
    ctx3_d.wx   = it2_q.wx;
    ctx3_d.wy   = it2_q.wy;
    ctx3_d.dex  = dex2_q;
    ctx3_d.dey  = dey2_q;
    ctx3_d.nx   = it2_q.nx;
    ctx3_d.ny   = it2_q.ny;
    ctx3_d.dx   = it2_q.dx;
    ctx3_d.dy   = it2_q.dy;
    ctx3_d.len  = it2_q.len;
  end

  logic        v3_q;
  swc_ctx_t    ctx3_q;
  logic [49:0] a3_q;
  logic [50:0] b3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx3_q <= ctx3_d;
      a3_q   <= amag;
      b3_q   <= bmag;
    end
  end

  // stage 4: shift both operands until the divisor fits 32 bits, clamp t to 1
  logic [50:0] an, bn;
  logic [31:0] num_d, den_d;

  always_comb begin
    an = {1'b0, a3_q};
    bn = b3_q;
    for (int s = 16; s >= 1; s = s / 2) begin
      if ((bn >> (32 + s)) != '0) begin
        an = an >> s;
        bn = bn >> s;
      end
    end
    if ((bn >> 32) != '0) begin
      an = an >> 1;
      bn = bn >> 1;
    end
    den_d = bn[31:0];
    num_d = (an > bn) ? bn[31:0] : an[31:0];
  end

  logic        v4_q;
  swc_ctx_t    ctx4_q;
  logic [31:0] num4_q, den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx4_q <= ctx3_q;
      num4_q <= num_d;
      den4_q <= den_d;
    end
  end

  assign valid_o = v4_q;
  assign ctx_o   = ctx4_q;
  assign num_o   = num4_q;
  assign den_o   = den4_q;

endmodule

[rtl/swc_div.sv]
// ----------------------------------------------------------------------------
// swc_div
// Pipelined restoring divider, one quotient bit per stage:
// t = floor(num * 2^T_FRAC / den) for num <= den.
// ----------------------------------------------------------------------------
module swc_div import swc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  swc_ctx_t       ctx_i,
  input  logic [31:0]    num_i,
  input  logic [31:0]    den_i,
  output logic           valid_o,
  output swc_ctx_t       ctx_o,
  output logic [T_W-1:0] quo_o
);

  localparam int unsigned NST = T_W;

  logic [NST-1:0] vld_q;
  swc_ctx_t       ctx_q [NST];
  logic [31:0]    rem_q [NST];
  logic [31:0]    den_q [NST];
  logic [T_W-1:0] quo_q [NST];

  // trial subtraction of each stage
  logic [32:0]    trial [NST];
  logic [31:0]    dsel  [NST];
  logic [NST-1:0] take;

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        trial[k] = {1'b0, num_i};
        dsel[k]  = den_i;
      end else begin
        trial[k] = {rem_q[k-1], 1'b0};
        dsel[k]  = den_q[k-1];
      end
      take[k] = (trial[k] >= {1'b0, dsel[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NST; k++) begin
        rem_q[k] <= take[k] ? 32'(trial[k] - {1'b0, dsel[k]}) : trial[k][31:0];
        den_q[k] <= dsel[k];
        if (k == 0) begin
          ctx_q[k] <= ctx_i;
          quo_q[k] <= {{(T_W-1){1'b0}}, take[k]};
        end else begin
          ctx_q[k] <= ctx_q[k-1];
          quo_q[k] <= {quo_q[k-1][T_W-2:0], take[k]};
        end
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign ctx_o   = ctx_q[NST-1];
  assign quo_o   = quo_q[NST-1];

endmodule

[rtl/swc_back.sv]
// ----------------------------------------------------------------------------
// swc_back
// Crossing point, pull-back, extent test and output register, five stages.
// ----------------------------------------------------------------------------
module swc_back import swc_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  swc_ctx_t           ctx_i,
  input  logic [T_W-1:0]     quo_i,
  input  logic [RAD_W-1:0]   radius_i,
  output logic               valid_o,
  output logic               crossed_o,
  output logic signed [31:0] result_x_o,
  output logic signed [31:0] result_y_o
);

  localparam int unsigned LIM_W = 48 + COORD_FRAC_BITS;
  localparam int unsigned CMP_W = (LIM_W > 67) ? LIM_W : 67;
  localparam int unsigned PM_W  = RAD_W + 16;
  localparam int unsigned PO_W  = PM_W + 1 - VEC_FRAC;

  // stage 1: path offset and pull-back products
  logic [31:0] mdx, mdy;
  logic [15:0] mnx, mny;

  always_comb begin
    mdx = ctx_i.dex[32] ? 32'(-ctx_i.dex) : ctx_i.dex[31:0];
    mdy = ctx_i.dey[32] ? 32'(-ctx_i.dey) : ctx_i.dey[31:0];
    mnx = ctx_i.nx[15] ? 16'(-ctx_i.nx) : 16'(ctx_i.nx);
    mny = ctx_i.ny[15] ? 16'(-ctx_i.ny) : 16'(ctx_i.ny);
  end

  logic                 v1_q;
  swc_ctx_t             ctx1_q;
  logic [31+T_W:0]      mx_q, my_q;
  logic                 sgx_q, sgy_q;
  logic [PM_W-1:0]      px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx1_q <= ctx_i;
      mx_q   <= mdx * quo_i;
      my_q   <= mdy * quo_i;
      sgx_q  <= ctx_i.dex[32] != ctx_i.neg;
      sgy_q  <= ctx_i.dey[32] != ctx_i.neg;
      px_q   <= radius_i * mnx;
      py_q   <= radius_i * mny;
    end
  end

  // stage 2: round, form the crossing point and the signed pull-back
  logic [32+T_W:0]      rmx, rmy;
  logic [31:0]          ox, oy;
  logic signed [33:0]   cxs, cys;
  logic signed [31:0]   cx_d, cy_d;
  logic [PM_W:0]        rpx, rpy;
  logic [PO_W-1:0]      pmx, pmy;
  logic signed [PO_W:0] pox_d, poy_d;

  always_comb begin
    rmx = {1'b0, mx_q} + (33'(1) << (T_FRAC - 1));
    rmy = {1'b0, my_q} + (33'(1) << (T_FRAC - 1));
    ox  = rmx[T_FRAC+31:T_FRAC];
    oy  = rmy[T_FRAC+31:T_FRAC];
    cxs = sgx_q ? ({{2{ctx1_q.sx[31]}}, ctx1_q.sx} - {2'b00, ox})
                : ({{2{ctx1_q.sx[31]}}, ctx1_q.sx} + {2'b00, ox});
    cys = sgy_q ? ({{2{ctx1_q.sy[31]}}, ctx1_q.sy} - {2'b00, oy})
                : ({{2{ctx1_q.sy[31]}}, ctx1_q.sy} + {2'b00, oy});
    // crossing stays between start and end, so 32 bits hold it
    cx_d = (ctx1_q.go && ctx1_q.nz) ? cxs[31:0] : ctx1_q.sx;
    cy_d = (ctx1_q.go && ctx1_q.nz) ? cys[31:0] : ctx1_q.sy;
    rpx  = {1'b0, px_q} + (PM_W'(1) << (VEC_FRAC - 1));
    rpy  = {1'b0, py_q} + (PM_W'(1) << (VEC_FRAC - 1));
    pmx  = rpx[PM_W:VEC_FRAC];
    pmy  = rpy[PM_W:VEC_FRAC];
    pox_d = ctx1_q.nx[15] ? -$signed({1'b0, pmx}) : $signed({1'b0, pmx});
    poy_d = ctx1_q.ny[15] ? -$signed({1'b0, pmy}) : $signed({1'b0, pmy});
  end

  logic                 v2_q;
  swc_ctx_t             ctx2_q;
  logic signed [31:0]   cx2_q, cy2_q;
  logic signed [PO_W:0] pox_q, poy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx2_q <= ctx1_q;
      cx2_q  <= cx_d;
      cy2_q  <= cy_d;
      pox_q  <= pox_d;
      poy_q  <= poy_d;
    end
  end

  // stage 3: offset from the wall point and pulled-back point
  logic                 v3_q;
  swc_ctx_t             ctx3_q;
  logic signed [31:0]   cx3_q, cy3_q;
  logic signed [32:0]   qx3_q, qy3_q;
  logic signed [33:0]   rx3_q, ry3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx3_q <= ctx2_q;
      cx3_q  <= cx2_q;
      cy3_q  <= cy2_q;
      qx3_q  <= {cx2_q[31], cx2_q} - {ctx2_q.wx[31], ctx2_q.wx};
      qy3_q  <= {cy2_q[31], cy2_q} - {ctx2_q.wy[31], ctx2_q.wy};
      rx3_q  <= {{2{cx2_q[31]}}, cx2_q} - 34'(pox_q);
      ry3_q  <= {{2{cy2_q[31]}}, cy2_q} - 34'(poy_q);
    end
  end

  // stage 4: squared distance and projection on the wall direction
  logic [32:0] mqx, mqy;

  always_comb begin
    mqx = qx3_q[32] ? 33'(-qx3_q) : 33'(qx3_q);
    mqy = qy3_q[32] ? 33'(-qy3_q) : 33'(qy3_q);
  end

  logic               v4_q;
  swc_ctx_t           ctx4_q;
  logic signed [31:0] cx4_q, cy4_q;
  logic signed [33:0] rx4_q, ry4_q;
  logic [65:0]        sqx_q, sqy_q;
  logic signed [48:0] dtx_q, dty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx4_q <= ctx3_q;
      cx4_q  <= cx3_q;
      cy4_q  <= cy3_q;
      rx4_q  <= rx3_q;
      ry4_q  <= ry3_q;
      sqx_q  <= mqx * mqx;
      sqy_q  <= mqy * mqy;
      dtx_q  <= qx3_q * ctx3_q.dx;
      dty_q  <= qy3_q * ctx3_q.dy;
    end
  end

  // stage 5: extent decision and result selection into the output register
  logic [66:0]        d2;
  logic signed [49:0] dot;
  logic               far, back, hit;
  logic signed [31:0] resx_d, resy_d;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  always_comb begin
    d2   = {1'b0, sqx_q} + {1'b0, sqy_q};
    dot  = {dtx_q[48], dtx_q} + {dty_q[48], dty_q};
    far  = CMP_W'(d2) > CMP_W'({ctx4_q.len, {COORD_FRAC_BITS{1'b0}}});
    back = dot[49];
    hit  = ctx4_q.go && !far && !back;
    if (!hit) begin
      resx_d = '0;
      resy_d = '0;
    end else if (ctx4_q.occl == CMD_OCCLUDE) begin
      resx_d = cx4_q;
      resy_d = cy4_q;
    end else begin
      resx_d = sat32(rx4_q);
      resy_d = sat32(ry4_q);
    end
  end

  logic               v5_q;
  logic               hit_q;
  logic signed [31:0] resx_q, resy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hit_q  <= hit;
      resx_q <= resx_d;
      resy_q <= resy_d;
    end
  end

  assign valid_o    = v5_q;
  assign crossed_o  = hit_q;
  assign result_x_o = resx_q;
  assign result_y_o = resy_q;

endmodule

[rtl/segment_wall_crossing_unit.sv]
// ----------------------------------------------------------------------------
// segment_wall_crossing_unit
// Decides whether a path crosses a wall segment and returns the crossing
// point, pulled back by the particle radius in collision mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one path and one wall per transaction, the command
//   (collision or occlusion) in tuser. Output stream m_axis: one result per
//   input, the crossed flag in tuser and the point in tdata.
//   cfg: writes the particle radius; always ready, write only while idle.
// Pipeline: input to output transaction passes 4 front stages,
//   31 divider stages at one quotient bit each and 5 back stages.
// Throughput: one transaction per cycle unless m_axis stalls; the pipeline is
//   fully pipelined and the divider stages set the depth, not the rate.
// Reset: all valid bits clear, so the pipeline is empty; the radius returns
//   to 5.0.
// Stall: while a result waits on m_axis, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated. tready follows
//   m_axis_tready combinationally.
// ----------------------------------------------------------------------------
module segment_wall_crossing_unit import swc_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // start_x, start_y, end_x, end_y, wall_x, wall_y, normal_x, normal_y,
  // dir_x, dir_y, wall_len_sq
  input  logic [303:0]       s_axis_tdata,
  // cmd
  input  logic               s_axis_tuser,
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // result_x, result_y
  output logic [63:0]        m_axis_tdata,
  // crossed
  output logic               m_axis_tuser,
  // radius configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RAD_W-1:0]   cfg_data_i
);

  // radius register
  logic [RAD_W-1:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  // global advance: pipeline moves unless a result is held
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // unpack the input transaction
  swc_in_t item;
  always_comb begin
    item.occl = s_axis_tuser;
    item.sx   = s_axis_tdata[31:0];
    item.sy   = s_axis_tdata[63:32];
    item.ex   = s_axis_tdata[95:64];
    item.ey   = s_axis_tdata[127:96];
    item.wx   = s_axis_tdata[159:128];
    item.wy   = s_axis_tdata[191:160];
    item.nx   = s_axis_tdata[207:192];
    item.ny   = s_axis_tdata[223:208];
    item.dx   = s_axis_tdata[239:224];
    item.dy   = s_axis_tdata[255:240];
    item.len  = s_axis_tdata[303:256];
  end

  logic           f_valid, d_valid;
  swc_ctx_t       f_ctx, d_ctx;
  logic [31:0]    f_num, f_den;
  logic [T_W-1:0] d_quo;
  logic signed [31:0] res_x, res_y;

  swc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_axis_tvalid && s_axis_tready),
    .item_i  (item),
    .valid_o (f_valid),
    .ctx_o   (f_ctx),
    .num_o   (f_num),
    .den_o   (f_den)
  );

  swc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_valid),
    .ctx_i   (f_ctx),
    .num_i   (f_num),
    .den_i   (f_den),
    .valid_o (d_valid),
    .ctx_o   (d_ctx),
    .quo_o   (d_quo)
  );

  swc_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (d_valid),
    .ctx_i      (d_ctx),
    .quo_i      (d_quo),
    .radius_i   (radius_q),
    .valid_o    (m_axis_tvalid),
    .crossed_o  (m_axis_tuser),
    .result_x_o (res_x),
    .result_y_o (res_y)
  );

  assign m_axis_tdata = {res_y, res_x};

`ifndef SYNTHESIS
  // a miss always reports the origin
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("miss with nonzero point");

  // input is only held off by a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // a stalled result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
`endif

endmodule

[tb/sv/swc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swc_checker
// Watches the input, output and radius channels of the wall crossing unit,
// predicts each result from the accepted inputs and compares them in order.
// ----------------------------------------------------------------------------
module swc_checker import swc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [303:0]     s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [63:0]      m_axis_tdata,
  input  logic             m_axis_tuser,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_o,
  input  logic [RAD_W-1:0] cfg_data_i,
  output int               fail_cnt_o,
  output int               pending_o
);

  typedef struct packed {
    logic        crossed;
    logic [31:0] rx;
    logic [31:0] ry;
  } crossing_t;

  // expected results, in order of acceptance
  localparam int EXP_DEPTH = 1024;

  crossing_t        exp_mem [EXP_DEPTH];
  int               wr_idx, rd_idx;
  logic [RAD_W-1:0] radius_q;
  int               mism_cnt;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // (E-S)*t with rounding of halves up in magnitude
  function automatic logic signed [63:0] path_offset(logic signed [63:0] delta,
                                                     logic [63:0] t, logic neg);
    logic [63:0] m;
    logic [63:0] q;
    m = delta < 0 ? -delta : delta;
    q = (m * t + (64'd1 << (T_FRAC - 1))) >> T_FRAC;
    return ((delta < 0) != neg) ? -$signed(q) : $signed(q);
  endfunction

  // R*n/2^14, halves away from zero
  function automatic logic signed [63:0] radius_offset(logic [63:0] r,
                                                       logic signed [63:0] n);
    logic [63:0] q;
    q = (r * (n < 0 ? -n : n) + (64'd1 << (VEC_FRAC - 1))) >> VEC_FRAC;
    return n < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic crossing_t predict_crossing(swc_in_t p, logic [RAD_W-1:0] rad);
    logic signed [63:0] sx, sy, ex, ey, wx, wy, nx, ny, dx, dy;
    logic signed [63:0] ds, de, s1, s2, cx, cy, qx, qy;
    logic [63:0]        a, b, t;
    logic [127:0]       d2, lim;
    logic               same, neg, hit;
    crossing_t          r;
    sx = p.sx; sy = p.sy; ex = p.ex; ey = p.ey; wx = p.wx; wy = p.wy;
    nx = p.nx; ny = p.ny; dx = p.dx; dy = p.dy;
    hit = 1'b0; cx = sx; cy = sy;
    ds = (sx - wx) * nx + (sy - wy) * ny;
    de = (ex - wx) * nx + (ey - wy) * ny;
    same = (ds > 0 && de > 0) || (ds < 0 && de < 0);
    s1 = -ds;
    s2 = de - ds;
    if (!same && (p.occl || s1 >= 0)) begin
      if (s2 != 0) begin
        a = s1 < 0 ? -s1 : s1;
        b = s2 < 0 ? -s2 : s2;
        neg = (s1 < 0) != (s2 < 0);
        while (b >= (64'd1 << 32)) begin
          a = a >> 1;
          b = b >> 1;
        end
        if (a > b) a = b;
        t = (a << T_FRAC) / b;
        cx = sx + path_offset(ex - sx, t, neg);
        cy = sy + path_offset(ey - sy, t, neg);
      end
      qx = cx - wx;
      qy = cy - wy;
      d2 = {64'd0, qx < 0 ? -qx : qx} * {64'd0, qx < 0 ? -qx : qx}
         + {64'd0, qy < 0 ? -qy : qy} * {64'd0, qy < 0 ? -qy : qy};
      lim = {80'd0, p.len} << FRAC_BITS_DEF;
      hit = !(d2 > lim) && !((qx * dx + qy * dy) < 0);
    end
    if (!hit) begin
      r = '0;
    end else begin
      if (!p.occl) begin
        cx = cx - radius_offset(64'(rad), nx);
        cy = cy - radius_offset(64'(rad), ny);
      end
      r.crossed = 1'b1;
      r.rx = sat32(cx);
      r.ry = sat32(cy);
    end
    return r;
  endfunction

  assign fail_cnt_o = mism_cnt;
  assign pending_o  = wr_idx - rd_idx;

  // capture inputs, radius writes and results
  always @(posedge clk_i or negedge rst_ni) begin
    swc_in_t   pin;
    crossing_t got, want;
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      wr_idx   = 0;
      rd_idx   = 0;
      mism_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) radius_q <= cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        pin.occl = s_axis_tuser;
        {pin.len, pin.dy, pin.dx, pin.ny, pin.nx, pin.wy, pin.wx,
         pin.ey, pin.ex, pin.sy, pin.sx} = s_axis_tdata;
        exp_mem[wr_idx % EXP_DEPTH] = predict_crossing(pin, radius_q);
        wr_idx = wr_idx + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.crossed = m_axis_tuser;
        got.rx = m_axis_tdata[31:0];
        got.ry = m_axis_tdata[63:32];
        if (wr_idx == rd_idx) begin
          if (mism_cnt < 10) $display("unexpected result %h", got);
          mism_cnt = mism_cnt + 1;
        end else begin
          want = exp_mem[rd_idx % EXP_DEPTH];
          rd_idx = rd_idx + 1;
          if (got !== want) begin
            if (mism_cnt < 10)
              $display("mismatch: exp crossed %b x %h y %h, got crossed %b x %h y %h",
                       want.crossed, want.rx, want.ry, got.crossed, got.rx, got.ry);
            mism_cnt = mism_cnt + 1;
          end
        end
      end
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random paths and walls into the wall crossing unit
// with random gaps and output stalls, changing the radius between phases.
// ----------------------------------------------------------------------------
module testbench;
  import swc_pkg::*;

  localparam int LATENCY = 40;
  localparam int LIMIT   = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [303:0]     s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [63:0]      m_axis_tdata;
  logic             m_axis_tuser;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [RAD_W-1:0] cfg_data_i = '0;
  int               fail_cnt, pending, cycle_cnt;
  logic             timed_out;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_wall_crossing_unit dut (.*);
  swc_checker u_chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  // receiver: random stalls per transaction
  initial begin
    int w;
    forever begin
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic cmd, logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                           logic [31:0] ey, logic [31:0] wx, logic [31:0] wy,
                           logic [15:0] nx, logic [15:0] ny, logic [15:0] dx,
                           logic [15:0] dy, logic [47:0] len, bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 10);
    if (w > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {len, dy, dx, ny, nx, wy, wx, ey, ex, sy, sx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic set_radius(logic [RAD_W-1:0] r);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random unit-ish vector pairs: normal and a perpendicular direction
  task automatic random_item(bit no_gap);
    logic [31:0] wx, wy, sx, sy, ex, ey;
    logic signed [15:0] nx, ny;
    logic [47:0] len;
    int k, sc;
    k = $urandom_range(0, 7);
    case (k)
      0: begin nx = 16'sd16384; ny = 16'sd0; end
      1: begin nx = -16'sd16384; ny = 16'sd0; end
      2: begin nx = 16'sd0; ny = 16'sd16384; end
      3: begin nx = 16'sd0; ny = -16'sd16384; end
      4: begin nx = 16'sd11585; ny = 16'sd11585; end
      5: begin nx = -16'sd11585; ny = 16'sd11585; end
      6: begin nx = 16'($urandom_range(0, 32768) - 16384); ny = 16'($urandom); end
      default: begin nx = 16'($urandom); ny = 16'($urandom); end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      // raw noise over the full field ranges
      send_item(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                48'({$urandom, $urandom}), no_gap);
    end else begin
      sc = $urandom_range(12, 26);
      wx = $urandom_range(0, 1 << sc) - (1 << (sc - 1));
      wy = $urandom_range(0, 1 << sc) - (1 << (sc - 1));
      sx = wx + $urandom_range(0, 1 << sc) - (1 << (sc - 1));
      sy = wy + $urandom_range(0, 1 << sc) - (1 << (sc - 1));
      ex = wx + $urandom_range(0, 1 << sc) - (1 << (sc - 1));
      ey = wy + $urandom_range(0, 1 << sc) - (1 << (sc - 1));
      len = 48'($urandom_range(0, 1 << (2 * sc - 16 > 30 ? 30 : 2 * sc - 16)));
      if ($urandom_range(0, 3) == 0) len = 48'({$urandom, $urandom});
      send_item(1'($urandom_range(0, 1)), sx, sy, ex, ey, wx, wy, nx, ny,
                -ny, nx, len, no_gap);
    end
  endtask

  initial begin
    int burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: crossing through a vertical wall at x = 10, normal +x
    send_item(CMD_COLLIDE, 32'sd0, 32'sd5 << 16, 32'sd20 << 16, 32'sd5 << 16,
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    send_item(CMD_OCCLUDE, 32'sd0, 32'sd5 << 16, 32'sd20 << 16, 32'sd5 << 16,
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    // start outside in collision, then occlusion from the outer side
    send_item(CMD_COLLIDE, 32'sd20 << 16, 32'sd5 << 16, 32'sd0, 32'sd5 << 16,
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    send_item(CMD_OCCLUDE, 32'sd20 << 16, 32'sd5 << 16, 32'sd0, 32'sd5 << 16,
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    // same side, endpoint on line, both on line
    send_item(CMD_COLLIDE, 32'sd0, 32'sd5 << 16, 32'sd5 << 16, 32'sd5 << 16,
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    send_item(CMD_COLLIDE, 32'sd0, 32'sd5 << 16, 32'sd10 << 16, 32'sd5 << 16,
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    send_item(CMD_OCCLUDE, 32'sd10 << 16, 32'sd3 << 16, 32'sd10 << 16, 32'sd7 << 16,
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    // beyond the wall length, behind the first point
    send_item(CMD_OCCLUDE, 32'sd0, 32'sd50 << 16, 32'sd20 << 16, 32'sd50 << 16,
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    send_item(CMD_OCCLUDE, 32'sd0, -(32'sd5 << 16), 32'sd20 << 16, -(32'sd5 << 16),
              32'sd10 << 16, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              48'd100 << 16, 0);
    // field extremes
    send_item(CMD_COLLIDE, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h0, 32'h0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 48'hffffffffffff, 0);
    send_item(CMD_OCCLUDE, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
              48'hffffffffffff, 0);
    send_item(CMD_COLLIDE, 32'hffffffff, 32'h0, 32'h0, 32'hffffffff, 32'h0, 32'h0,
              -16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 48'd0, 0);
    send_item(CMD_COLLIDE, 32'h7fff0000, 32'h0, 32'h7fffffff, 32'h0, 32'h7fff8000, 32'h0,
              -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 48'hffffffffffff, 0);
    for (int i = 0; i < 8; i++) random_item(0);
    // radius phases, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_radius(23'd0);
        1: set_radius(23'd4194304);
        2: set_radius(23'h7fffff);
        3: set_radius(RADIUS_RST);
        default: set_radius(23'($urandom_range(0, 4194304)));
      endcase
      for (int i = 0; i < 300; i++) begin
        burst = $urandom_range(0, 4);
        random_item(burst == 0);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    timed_out = 1'b0;
    if (fail_cnt == 0 && !timed_out) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
